/* hw/rtl/twos_pkg.sv */
// shared types, constants and arithmetic helpers for the odometry step block
`timescale 1ns / 1ps

package twos_pkg;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_STRAIGHT_TPM = 3'd0,
        REG_MIDDLE_TPM   = 3'd1,
        REG_WHEEL_TRACK  = 3'd2,
        REG_MIDDLE_OFS   = 3'd3,
        REG_MAX_TICKS    = 3'd4
    } twos_reg_e;

    typedef struct packed {
        logic [31:0] straight_ticks_per_meter;
        logic [31:0] middle_ticks_per_meter;
        logic [31:0] wheel_track;
        logic [31:0] middle_wheel_offset;
        logic [14:0] max_tick_delta;
    } twos_cfg_t;

    typedef struct packed {
        logic signed [31:0] heading;
        logic signed [15:0] middle_ticks;
        logic signed [15:0] right_ticks;
        logic signed [15:0] left_ticks;
        logic               skipped;
    } twos_item_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // divider sizes: tick scaling, heading change, chord factor
    localparam int DIV_SCALE_W = 56;
    localparam int DIV_HEAD_W  = 61;
    localparam int DIV_CHORD_W = 60;
    localparam int DIV_DEN_W   = 32;

    // angle datapath, q30 radians
    localparam int AW = 36;
    localparam int ZW = 34;

    localparam logic signed [AW-1:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic [AW-1:0] TWO_PI_X4 = 36'd26986075408;
    localparam logic [AW-1:0] TWO_PI_X2 = 36'd13493037704;
    localparam logic [AW-1:0] TWO_PI_X1 = 36'd6746518852;
    localparam logic signed [ZW-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
        32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
    };

    localparam logic signed [71:0] SAT_MAX   = 72'sd2147483647;
    localparam logic signed [71:0] SAT_MIN   = -72'sd2147483648;
    localparam logic signed [71:0] ONE_Q30_W = 72'sd1073741824;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_one(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > ONE_Q30_W) begin
            r = 32'sd1073741824;
        end else if (v < -ONE_Q30_W) begin
            r = -32'sd1073741824;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

endpackage

/* hw/rtl/twos_div.sv */
// pipelined restoring divider, one quotient bit per stage, signed result
`timescale 1ns / 1ps

module twos_div
    import twos_pkg::*;
#(
    parameter int NW = 56,
    parameter int DW = 32
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [NW-1:0]        num,
    input  logic [DW-1:0]        den,
    input  logic                 neg,
    output logic signed [NW:0]   q
);

    logic [NW-1:0] num_reg  [NW];
    logic [NW-1:0] quo_reg  [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [NW-1:0] neg_reg;
    logic [NW-1:0] zero_reg;

    logic [NW-1:0] num_next [NW];
    logic [NW-1:0] quo_next [NW];
    logic [DW-1:0] rem_next [NW];

    always_comb begin
        logic [NW-1:0] pn;
        logic [NW-1:0] pq;
        logic [DW-1:0] pr;
        logic [DW-1:0] pd;
        logic [DW:0]   trial;
        logic [DW+1:0] diff;
        for (int i = 0; i < NW; i++) begin
            if (i == 0) begin
                pn = num;
                pq = '0;
                pr = '0;
                pd = den;
            end else begin
                pn = num_reg[i-1];
                pq = quo_reg[i-1];
                pr = rem_reg[i-1];
                pd = den_reg[i-1];
            end
            trial = {pr, pn[NW-1]};
            diff  = {1'b0, trial} - {2'b00, pd};
            num_next[i] = {pn[NW-2:0], 1'b0};
            quo_next[i] = {pq[NW-2:0], ~diff[DW+1]};
            rem_next[i] = diff[DW+1] ? trial[DW-1:0] : diff[DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NW; i++) begin
                num_reg[i] <= num_next[i];
                quo_reg[i] <= quo_next[i];
                rem_reg[i] <= rem_next[i];
                if (i == 0) begin
                    den_reg[i]  <= den;
                    neg_reg[i]  <= neg;
                    zero_reg[i] <= (den == '0);
                end else begin
                    den_reg[i]  <= den_reg[i-1];
                    neg_reg[i]  <= neg_reg[i-1];
                    zero_reg[i] <= zero_reg[i-1];
                end
            end
        end
    end

    always_comb begin
        if (zero_reg[NW-1]) begin
            q = '0;
        end else if (neg_reg[NW-1]) begin
            q = -$signed({1'b0, quo_reg[NW-1]});
        end else begin
            q = $signed({1'b0, quo_reg[NW-1]});
        end
    end

endmodule

/* hw/rtl/twos_dly.sv */
// stallable delay line that keeps side data aligned with the long units
`timescale 1ns / 1ps

module twos_dly
    import twos_pkg::*;
#(
    parameter int W = 32,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [D];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < D; i++) begin
                if (i == 0) begin
                    tap_reg[i] <= din;
                end else begin
                    tap_reg[i] <= tap_reg[i-1];
                end
            end
        end
    end

    assign dout = tap_reg[D-1];

endmodule

/* hw/rtl/twos_sincos.sv */
// pipelined angle reduction and cordic rotation giving cos and sin in q2.30
`timescale 1ns / 1ps

module twos_sincos
    import twos_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [AW-1:0] angle,
    output logic signed [31:0]   cos_q,
    output logic signed [31:0]   sin_q
);

    localparam int IT = CORDIC_ITERATIONS;

    logic          sgn0_reg, sgn1_reg, sgn2_reg, sgn3_reg;
    logic [AW-1:0] mag0_reg, mag1_reg, mag2_reg, mag3_reg;
    logic signed [ZW-1:0] z4_reg, z5_reg;
    logic          flip5_reg;
    logic signed [ZW-1:0] z4_next, z5_next;
    logic          flip5_next;

    logic signed [ZW-1:0] x_reg [IT];
    logic signed [ZW-1:0] y_reg [IT];
    logic signed [ZW-1:0] z_reg [IT];
    logic [IT-1:0]        flp_reg;
    logic signed [ZW-1:0] x_next [IT];
    logic signed [ZW-1:0] y_next [IT];
    logic signed [ZW-1:0] z_next [IT];

    logic signed [31:0] cos_reg, sin_reg;

    // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
    always_comb begin
        logic signed [AW-1:0] zw;
        logic signed [AW-1:0] zf;
        zw = sgn3_reg ? -$signed(mag3_reg) : $signed(mag3_reg);
        if (zw > PI_Q30) begin
            zw = zw - TWO_PI_Q30;
        end else if (zw < -PI_Q30) begin
            zw = zw + TWO_PI_Q30;
        end
        z4_next = ZW'(zw);
        zf = AW'(z4_reg);
        flip5_next = 1'b0;
        if (zf > HALF_PI_Q30) begin
            zf = zf - PI_Q30;
            flip5_next = 1'b1;
        end else if (zf < -HALF_PI_Q30) begin
            zf = zf + PI_Q30;
            flip5_next = 1'b1;
        end
        z5_next = ZW'(zf);
    end

    always_comb begin
        logic signed [ZW-1:0] xp, yp, zp, at;
        for (int i = 0; i < IT; i++) begin
            if (i == 0) begin
                xp = GAIN_Q30;
                yp = '0;
                zp = z5_reg;
            end else begin
                xp = x_reg[i-1];
                yp = y_reg[i-1];
                zp = z_reg[i-1];
            end
            at = $signed({2'b00, ATAN_Q30[i]});
            if (!zp[ZW-1]) begin
                x_next[i] = xp - (yp >>> i);
                y_next[i] = yp + (xp >>> i);
                z_next[i] = zp - at;
            end else begin
                x_next[i] = xp + (yp >>> i);
                y_next[i] = yp - (xp >>> i);
                z_next[i] = zp + at;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sgn0_reg <= angle[AW-1];
            mag0_reg <= angle[AW-1] ? AW'(-angle) : AW'(angle);
            sgn1_reg <= sgn0_reg;
            mag1_reg <= (mag0_reg >= TWO_PI_X4) ? mag0_reg - TWO_PI_X4 : mag0_reg;
            sgn2_reg <= sgn1_reg;
            mag2_reg <= (mag1_reg >= TWO_PI_X2) ? mag1_reg - TWO_PI_X2 : mag1_reg;
            sgn3_reg <= sgn2_reg;
            mag3_reg <= (mag2_reg >= TWO_PI_X1) ? mag2_reg - TWO_PI_X1 : mag2_reg;
            z4_reg    <= z4_next;
            z5_reg    <= z5_next;
            flip5_reg <= flip5_next;
            for (int i = 0; i < IT; i++) begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
                if (i == 0) begin
                    flp_reg[i] <= flip5_reg;
                end else begin
                    flp_reg[i] <= flp_reg[i-1];
                end
            end
            if (flp_reg[IT-1]) begin
                cos_reg <= clamp_one(-72'(x_reg[IT-1]));
                sin_reg <= clamp_one(-72'(y_reg[IT-1]));
            end else begin
                cos_reg <= clamp_one(72'(x_reg[IT-1]));
                sin_reg <= clamp_one(72'(y_reg[IT-1]));
            end
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

/* hw/rtl/twos_front.sv */
// input side: takes beats, flags out-of-range tick deltas, short queue to the back
`timescale 1ns / 1ps

module twos_front
    import twos_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [14:0] max_tick_delta,
    output twos_item_t  item,
    output logic        item_valid,
    input  logic        pop
);

    twos_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    twos_item_t         in_item;
    logic               push;
    logic [15:0]        lim;

    assign lim = {1'b0, max_tick_delta};

    always_comb begin
        in_item.left_ticks   = s_tdata[15:0];
        in_item.right_ticks  = s_tdata[31:16];
        in_item.middle_ticks = s_tdata[47:32];
        in_item.heading      = s_tdata[79:48];
        in_item.skipped      = (abs16(s_tdata[15:0]) > lim) ||
                               (abs16(s_tdata[31:16]) > lim) ||
                               (abs16(s_tdata[47:32]) > lim);
    end

    assign s_tready   = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign item_valid = (cnt_reg != '0);
    assign item       = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/twos_back.sv */
// execution pipeline: scaling, heading change, arc chord and field rotation
`timescale 1ns / 1ps

module twos_back
    import twos_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  twos_cfg_t   cfg,
    input  twos_item_t  item,
    input  logic        item_valid,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,
    output logic [0:0]  m_tuser
);

    localparam int LA  = DIV_SCALE_W;
    localparam int LD  = DIV_HEAD_W;
    localparam int LK  = DIV_CHORD_W;
    localparam int LS  = CORDIC_ITERATIONS + 7;
    localparam int LAT = LA + LD + LS + LK + 8;

    logic [LAT-1:0] vld_reg;
    logic           en;

    assign en  = !vld_reg[LAT-1] || m_tready;
    assign pop = en && item_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], pop};
        end
    end

    // tick scaling
    logic signed [DIV_SCALE_W:0] ql, qr, qm;
    logic [32:0] hs_b;

    twos_div #(.NW(DIV_SCALE_W), .DW(DIV_DEN_W)) u_div_l (
        .aclk(aclk), .en(en),
        .num({abs16(item.left_ticks), 40'd0}),
        .den(cfg.straight_ticks_per_meter),
        .neg(item.left_ticks[15]), .q(ql)
    );
    twos_div #(.NW(DIV_SCALE_W), .DW(DIV_DEN_W)) u_div_r (
        .aclk(aclk), .en(en),
        .num({abs16(item.right_ticks), 40'd0}),
        .den(cfg.straight_ticks_per_meter),
        .neg(item.right_ticks[15]), .q(qr)
    );
    twos_div #(.NW(DIV_SCALE_W), .DW(DIV_DEN_W)) u_div_m (
        .aclk(aclk), .en(en),
        .num({abs16(item.middle_ticks), 40'd0}),
        .den(cfg.middle_ticks_per_meter),
        .neg(item.middle_ticks[15]), .q(qm)
    );
    twos_dly #(.W(33), .D(LA + 1)) u_dly_a (
        .aclk(aclk), .en(en), .din({item.heading, item.skipped}), .dout(hs_b)
    );

    logic signed [31:0]          dl_reg, dr_reg;
    logic signed [DIV_SCALE_W:0] qm_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dl_reg <= sat32(72'(ql));
            dr_reg <= sat32(72'(qr));
            qm_reg <= qm;
        end
    end

    // heading change
    logic signed [32:0]         diff_b;
    logic [32:0]                dmag_b;
    logic signed [DIV_HEAD_W:0] qd;

    assign diff_b = {dl_reg[31], dl_reg} - {dr_reg[31], dr_reg};
    assign dmag_b = diff_b[32] ? 33'(-diff_b) : 33'(diff_b);

    twos_div #(.NW(DIV_HEAD_W), .DW(DIV_DEN_W)) u_div_d (
        .aclk(aclk), .en(en), .num({dmag_b, 28'd0}), .den(cfg.wheel_track),
        .neg(diff_b[32]), .q(qd)
    );

    logic signed [31:0]          dr_c, head_c;
    logic signed [DIV_SCALE_W:0] qm_c;
    logic                        skip_c;

    twos_dly #(.W(122), .D(LD + 1)) u_dly_b (
        .aclk(aclk), .en(en), .din({dr_reg, qm_reg, hs_b}),
        .dout({dr_c, qm_c, head_c, skip_c})
    );

    logic signed [31:0] dth_c_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dth_c_reg <= sat32(72'(qd));
        end
    end

    // middle wheel rotation correction
    logic signed [64:0]          prod_m_reg;
    logic signed [DIV_SCALE_W:0] qm_c1_reg;
    logic signed [31:0]          dm_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_m_reg <= dth_c_reg * $signed({1'b0, cfg.middle_wheel_offset});
            qm_c1_reg  <= qm_c;
            dm_reg     <= sat32(72'(qm_c1_reg) - 72'(prod_m_reg >>> 28));
        end
    end

    // half angle and mid-step heading
    logic signed [AW-1:0] ang_half, ang_head;
    logic signed [31:0]   cos1, sin1, cos2, sin2;

    assign ang_half = {{3{dth_c_reg[31]}}, dth_c_reg, 1'b0};
    assign ang_head = {{2{head_c[31]}}, head_c, 2'b00} + ang_half;

    twos_sincos #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_sc_half (
        .aclk(aclk), .en(en), .angle(ang_half), .cos_q(cos1), .sin_q(sin1)
    );
    twos_sincos #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_sc_head (
        .aclk(aclk), .en(en), .angle(ang_head), .cos_q(cos2), .sin_q(sin2)
    );

    // chord factor
    logic signed [32:0] s2_e_reg;
    logic signed [31:0] dth_e;
    logic [31:0]        s2mag_e, dthmag_e;
    logic signed [DIV_CHORD_W:0] qk;

    twos_dly #(.W(32), .D(LS + 1)) u_dly_c (
        .aclk(aclk), .en(en), .din(dth_c_reg), .dout(dth_e)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_e_reg <= {sin1, 1'b0};
        end
    end

    assign s2mag_e  = s2_e_reg[32] ? 32'(-s2_e_reg) : 32'(s2_e_reg);
    assign dthmag_e = dth_e[31] ? 32'(-dth_e) : 32'(dth_e);

    twos_div #(.NW(DIV_CHORD_W), .DW(DIV_DEN_W)) u_div_k (
        .aclk(aclk), .en(en), .num({s2mag_e, 28'd0}), .den(dthmag_e),
        .neg(s2_e_reg[32] ^ dth_e[31]), .q(qk)
    );

    // realign everything with the chord factor
    logic signed [31:0] dth_f, dr_f, dm_f, cos_f, sin_f;
    logic signed [32:0] s2_f;
    logic               skip_f;
    logic signed [31:0] k_reg;

    twos_dly #(.W(65), .D(LS + LK + 2)) u_dly_d (
        .aclk(aclk), .en(en), .din({dth_c_reg, skip_c, dr_c}),
        .dout({dth_f, skip_f, dr_f})
    );
    twos_dly #(.W(32), .D(LS + LK)) u_dly_e (
        .aclk(aclk), .en(en), .din(dm_reg), .dout(dm_f)
    );
    twos_dly #(.W(64), .D(LK + 2)) u_dly_f (
        .aclk(aclk), .en(en), .din({cos2, sin2}), .dout({cos_f, sin_f})
    );
    twos_dly #(.W(33), .D(LK + 1)) u_dly_g (
        .aclk(aclk), .en(en), .din(s2_e_reg), .dout(s2_f)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg <= clamp_one(72'(qk));
        end
    end

    // local offset
    logic signed [63:0] kdm_reg, kdr_reg;
    logic signed [65:0] smw_reg, str_reg;
    logic signed [31:0] dm_g, dr_g, dth_g, cos_g, sin_g;
    logic               skip_g;
    logic signed [31:0] x_reg, y_reg, dth_h, cos_h, sin_h;
    logic               skip_h;

    always_ff @(posedge aclk) begin
        if (en) begin
            kdm_reg <= k_reg * dm_f;
            kdr_reg <= k_reg * dr_f;
            smw_reg <= s2_f * $signed({1'b0, cfg.middle_wheel_offset});
            str_reg <= s2_f * $signed({1'b0, cfg.wheel_track});
            dm_g    <= dm_f;
            dr_g    <= dr_f;
            dth_g   <= dth_f;
            cos_g   <= cos_f;
            sin_g   <= sin_f;
            skip_g  <= skip_f;

            if (dth_g == '0) begin
                x_reg <= dm_g;
                y_reg <= dr_g;
            end else begin
                x_reg <= sat32(72'(kdm_reg >>> 30) + 72'(smw_reg >>> 29));
                y_reg <= sat32(72'(kdr_reg >>> 30) + 72'(str_reg >>> 31));
            end
            dth_h  <= dth_g;
            cos_h  <= cos_g;
            sin_h  <= sin_g;
            skip_h <= skip_g;
        end
    end

    // field rotation
    logic signed [63:0] yc_reg, xs_reg, xc_reg, ys_reg;
    logic signed [31:0] dth_i;
    logic               skip_i;
    logic signed [71:0] dxw, dyw;
    logic signed [31:0] dx_reg, dy_reg, dth_o_reg;
    logic               skip_o_reg;

    assign dxw = 72'(yc_reg) - 72'(xs_reg);
    assign dyw = 72'(xc_reg) + 72'(ys_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            yc_reg <= y_reg * cos_h;
            xs_reg <= x_reg * sin_h;
            xc_reg <= x_reg * cos_h;
            ys_reg <= y_reg * sin_h;
            dth_i  <= dth_h;
            skip_i <= skip_h;

            if (skip_i) begin
                dx_reg    <= '0;
                dy_reg    <= '0;
                dth_o_reg <= '0;
            end else begin
                dx_reg    <= sat32(dxw >>> 30);
                dy_reg    <= sat32(dyw >>> 30);
                dth_o_reg <= dth_i;
            end
            skip_o_reg <= skip_i;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {dth_o_reg, dy_reg, dx_reg};
    assign m_tuser  = skip_o_reg;

endmodule

/* hw/rtl/three_wheel_odometry_step_top.sv */
// top level of the three tracking wheel odometry step block
`timescale 1ns / 1ps

// Takes one beat of left, right and middle tick deltas plus heading per clock and returns
// one beat of field displacement and heading change per input beat, in order. Sustained
// rate is one beat per cycle while m_tready does not stall a waiting result. The long
// units are five pipelined dividers that retire one quotient bit per stage (56, 61 and
// 60 bits long on the chain) and two pipelined cordic rotators of CORDIC_ITERATIONS + 7
// stages each. A four-entry queue sits behind the input so the input side keeps taking
// beats while a result waits on m_tready. Configuration is always ready; write it only
// while no beat is in flight.

module three_wheel_odometry_step_top
    import twos_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // left_ticks, right_ticks, middle_ticks, heading
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // delta_x, delta_y, delta_heading
    output logic [0:0]  m_tuser,   // skipped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    twos_cfg_t  cfg_reg;
    twos_item_t item;
    logic       item_valid;
    logic       pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.straight_ticks_per_meter <= 32'd65536;
            cfg_reg.middle_ticks_per_meter   <= 32'd65536;
            cfg_reg.wheel_track              <= 32'd16777216;
            cfg_reg.middle_wheel_offset      <= 32'd0;
            cfg_reg.max_tick_delta           <= 15'd1000;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_STRAIGHT_TPM: cfg_reg.straight_ticks_per_meter <= cfg_wdata;
                REG_MIDDLE_TPM:   cfg_reg.middle_ticks_per_meter   <= cfg_wdata;
                REG_WHEEL_TRACK:  cfg_reg.wheel_track              <= cfg_wdata;
                REG_MIDDLE_OFS:   cfg_reg.middle_wheel_offset      <= cfg_wdata;
                REG_MAX_TICKS:    cfg_reg.max_tick_delta           <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    twos_front u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .max_tick_delta(cfg_reg.max_tick_delta),
        .item(item),
        .item_valid(item_valid),
        .pop(pop)
    );

    twos_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg(cfg_reg),
        .item(item),
        .item_valid(item_valid),
        .pop(pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

endmodule

/* hw/rtl/twos_checker.sv */
// port-level checks for the odometry step block, bound to the top level
`timescale 1ns / 1ps

module twos_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // skipped beats carry all-zero data
    a_skip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 96'd0)
        else $error("skipped beat with nonzero data");

    // reset empties the pipe and the queue
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not empty after reset");

endmodule

bind three_wheel_odometry_step_top twos_checker u_twos_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
);
